[rtl/sbf_pkg.sv]
// Shared types, constants and helpers for the store buffer with forwarding.
package sbf_pkg;

	// Number of entries the buffer retains between transactions
	localparam int CAPACITY = 8;
	// Width of the entry count (holds 0 .. CAPACITY)
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ACT_STORE     = 2'd0,
		ACT_LOAD      = 2'd1,
		ACT_COMMIT    = 2'd2,
		ACT_FLUSH_ALL = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_COMMIT    = 2'd0,
		KIND_FORWARD   = 2'd1,
		KIND_READ_REQ  = 2'd2,
		KIND_POP_ERROR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SZ_8  = 2'd0,
		SZ_16 = 2'd1,
		SZ_32 = 2'd2,
		SZ_64 = 2'd3
	} size_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_FLUSH = 1'b1
	} state_t;

	// One buffered store
	typedef struct packed {
		logic [63:0] address;
		logic [63:0] value;
		logic [1:0]  width;
	} entry_t;

	// Per-cell control from the buffer controller
	typedef struct packed {
		logic shift;  // take the entry of the next younger cell
		logic write;  // capture the incoming store
		logic valid;  // cell holds a live entry
	} cell_ctl_t;

	// Keep only the bytes that the access width covers
	function automatic logic [63:0] width_mask(input logic [1:0] code);
		logic [63:0] m;
		begin
			unique case (size_t'(code))
				SZ_8:    m = 64'h0000_0000_0000_00FF;
				SZ_16:   m = 64'h0000_0000_0000_FFFF;
				SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
				SZ_64:   m = 64'hFFFF_FFFF_FFFF_FFFF;
				default: m = 64'hFFFF_FFFF_FFFF_FFFF;
			endcase
			return m;
		end
	endfunction

endpackage

[rtl/sbf_cell.sv]
// One slot of the store buffer: holds an entry, shifts towards the head, forwards on match.
module sbf_cell (
	input  logic               clk,
	input  sbf_pkg::cell_ctl_t ctl,
	input  sbf_pkg::entry_t    new_entry,
	input  sbf_pkg::entry_t    younger_entry,
	input  logic [63:0]        lookup_address,
	input  logic               hit_in,
	input  logic [63:0]        fwd_in,
	output sbf_pkg::entry_t    entry_q,
	output logic               hit_out,
	output logic [63:0]        fwd_out
);

	// Capture a new store, or advance the younger neighbour's entry
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			entry_q <= new_entry;
		end else if (ctl.shift) begin
			entry_q <= younger_entry;
		end
	end

	// A match here overrides any match from older cells
	always_comb begin
		if (ctl.valid && (entry_q.address == lookup_address)) begin
			hit_out = 1'b1;
			fwd_out = entry_q.value;
		end else begin
			hit_out = hit_in;
			fwd_out = fwd_in;
		end
	end

endmodule

[rtl/store_buffer_with_forwarding_core.sv]
// Top level of the FIFO store buffer with load forwarding.
// Usage:
//   Input channel (in_valid/in_ready) carries action, address, store_data and
//   size_code. Output channel (out_valid/out_ready) carries kind, mem_address,
//   data_out, width_out and last, one result per transaction.
//   The buffer is a row of CAPACITY cells, oldest entry at cell 0. A commit
//   takes the head cell and the row shifts one place towards it.
// Operation:
//   A store, load or commit-oldest transaction is handled as it is accepted; its result,
//   if any, appears in the output register on the next cycle. A load compares
//   every cell at once and the newest match wins through the chain of cells.
//   Flush-all is accepted, then drains the buffered entries one commit at a time,
//   pausing while the output register is full; no input is accepted until the
//   last commit is loaded. Input is accepted whenever no flush is under way and
//   the output register is empty or is being read in the same cycle.
// Reset: arst_n clears the entry count, flush state and output valid flag only.
// Stall:
//   While out_ready is low a pending result holds; in_ready drops and a flush
//   pauses until the result is taken.
module store_buffer_with_forwarding_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] address,
	input  logic [63:0] store_data,
	input  logic [1:0]  size_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [63:0] mem_address,
	output logic [63:0] data_out,
	output logic [1:0]  width_out,
	output logic        last
);

	localparam int NC = sbf_pkg::CAPACITY;
	localparam int CW = sbf_pkg::CNT_W;

	sbf_pkg::state_t    state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      wr_pos;
	logic               out_free;
	logic               accept;
	logic               push, pop;
	logic               emit;
	logic [1:0]         emit_kind;
	logic [63:0]        emit_address;
	logic [63:0]        emit_data;
	logic [1:0]         emit_width;
	logic               emit_last;
	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [63:0]        mem_address_q;
	logic [63:0]        data_out_q;
	logic [1:0]         width_out_q;
	logic               last_q;

	sbf_pkg::entry_t    new_entry;
	sbf_pkg::entry_t    entries [NC];
	sbf_pkg::entry_t    younger [NC];
	sbf_pkg::cell_ctl_t ctl [NC];
	logic               hit_chain [NC+1];
	logic [63:0]        fwd_chain [NC+1];

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == sbf_pkg::ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign new_entry = '{address: address, value: store_data, width: size_code};
	// Write slot after any head removal in the same cycle
	assign wr_pos    = count_q - CW'(pop);

	assign hit_chain[0] = 1'b0;
	assign fwd_chain[0] = 64'd0;

	// Row of cells, oldest at index 0
	for (genvar i = 0; i < NC; i++) begin : g_cell
		if (i == NC - 1) begin : g_tail
			assign younger[i] = new_entry;
		end else begin : g_mid
			assign younger[i] = entries[i+1];
		end

		assign ctl[i].shift = pop;
		assign ctl[i].write = push && (wr_pos == CW'(i));
		assign ctl[i].valid = (CW'(i) < count_q);

		sbf_cell u_cell (
			.clk            (clk),
			.ctl            (ctl[i]),
			.new_entry      (new_entry),
			.younger_entry  (younger[i]),
			.lookup_address (address),
			.hit_in         (hit_chain[i]),
			.fwd_in         (fwd_chain[i]),
			.entry_q        (entries[i]),
			.hit_out        (hit_chain[i+1]),
			.fwd_out        (fwd_chain[i+1])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbf_pkg::ST_IDLE: begin
				if (accept && (sbf_pkg::action_t'(action) == sbf_pkg::ACT_FLUSH_ALL)
						&& (count_q != '0)) begin
					state_d = sbf_pkg::ST_FLUSH;
				end
			end
			sbf_pkg::ST_FLUSH: begin
				if (out_free && (count_q == CW'(1))) begin
					state_d = sbf_pkg::ST_IDLE;
				end
			end
			default: state_d = sbf_pkg::ST_IDLE;
		endcase
	end

	// Buffer control and result selection
	always_comb begin
		push         = 1'b0;
		pop          = 1'b0;
		emit         = 1'b0;
		emit_kind    = sbf_pkg::KIND_COMMIT;
		emit_address = entries[0].address;
		emit_data    = entries[0].value & sbf_pkg::width_mask(entries[0].width);
		emit_width   = entries[0].width;
		emit_last    = 1'b1;
		unique case (state_q)
			sbf_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (sbf_pkg::action_t'(action))
						sbf_pkg::ACT_STORE: begin
							push = 1'b1;
							// Overflow drains the head as a commit
							if (count_q == CW'(NC)) begin
								pop  = 1'b1;
								emit = 1'b1;
							end
						end
						sbf_pkg::ACT_LOAD: begin
							emit         = 1'b1;
							emit_address = address;
							if (hit_chain[NC]) begin
								emit_kind  = sbf_pkg::KIND_FORWARD;
								emit_data  = fwd_chain[NC];
								emit_width = sbf_pkg::SZ_8;
							end else begin
								emit_kind  = sbf_pkg::KIND_READ_REQ;
								emit_data  = 64'd0;
								emit_width = size_code;
							end
						end
						sbf_pkg::ACT_COMMIT: begin
							emit = 1'b1;
							if (count_q == '0) begin
								emit_kind    = sbf_pkg::KIND_POP_ERROR;
								emit_address = 64'd0;
								emit_data    = 64'd0;
								emit_width   = sbf_pkg::SZ_8;
							end else begin
								pop = 1'b1;
							end
						end
						sbf_pkg::ACT_FLUSH_ALL: begin
							pop = 1'b0;
						end
						default: begin
							pop = 1'b0;
						end
					endcase
				end
			end
			sbf_pkg::ST_FLUSH: begin
				// Drain one entry per free output slot
				if (out_free) begin
					pop       = 1'b1;
					emit      = 1'b1;
					emit_last = (count_q == CW'(1));
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbf_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_q + CW'(push) - CW'(pop);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q        <= emit_kind;
			mem_address_q <= emit_address;
			data_out_q    <= emit_data;
			width_out_q   <= emit_width;
			last_q        <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign mem_address = mem_address_q;
	assign data_out    = data_out_q;
	assign width_out   = width_out_q;
	assign last        = last_q;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the store buffer with load forwarding.
module tb_top;

	// Cycle budget and settle time after the last expected result
	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 20;

	// One buffered store, as the predictor holds it
	typedef struct {
		logic [63:0]     address;
		logic [63:0]     value;
		sbf_pkg::size_t  width;
	} held_store_t;

	// One expected result transaction
	typedef struct {
		sbf_pkg::kind_t  kind;
		logic [63:0]     mem_address;
		logic [63:0]     data;
		logic [1:0]      width;
		logic            last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [63:0] address;
	logic [63:0] store_data;
	logic [1:0]  size_code;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [63:0] mem_address;
	logic [63:0] data_out;
	logic [1:0]  width_out;
	logic        last;

	held_store_t held_stores[$];
	result_t     awaited_results[$];

	int failures;
	int cycles;
	int items_sent;
	int kinds_seen[4];
	bit sender_jitter;
	bit receiver_stalls;

	store_buffer_with_forwarding_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.address    (address),
		.store_data (store_data),
		.size_code  (size_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.mem_address(mem_address),
		.data_out   (data_out),
		.width_out  (width_out),
		.last       (last)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Bytes that memory receives for a given access width
	function automatic logic [63:0] lane_mask(sbf_pkg::size_t code);
		case (code)
			sbf_pkg::SZ_8:  return 64'h0000_0000_0000_00FF;
			sbf_pkg::SZ_16: return 64'h0000_0000_0000_FFFF;
			sbf_pkg::SZ_32: return 64'h0000_0000_FFFF_FFFF;
			default:        return 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
	endfunction

	function automatic void await_result(sbf_pkg::kind_t k, logic [63:0] a, logic [63:0] d,
			logic [1:0] w, logic l);
		result_t r;
		r.kind = k;
		r.mem_address = a;
		r.data = d;
		r.width = w;
		r.last = l;
		awaited_results.push_back(r);
	endfunction

	// Drain the oldest held store as a write commit
	function automatic void drain_oldest(logic is_last);
		held_store_t e;
		e = held_stores.pop_front();
		await_result(sbf_pkg::KIND_COMMIT, e.address, e.value & lane_mask(e.width), e.width,
			is_last);
	endfunction

	// Work out the results that one accepted transaction causes
	function automatic void predict_buffer(sbf_pkg::action_t act, logic [63:0] a,
			logic [63:0] d, sbf_pkg::size_t sz);
		held_store_t e;
		bit hit;
		hit = 1'b0;
		case (act)
			sbf_pkg::ACT_STORE: begin
				e.address = a;
				e.value = d;
				e.width = sz;
				held_stores.push_back(e);
				if (held_stores.size() > sbf_pkg::CAPACITY)
					drain_oldest(1'b1);
			end
			sbf_pkg::ACT_LOAD: begin
				// newest match wins, exact address only
				for (int i = held_stores.size() - 1; i >= 0 && !hit; i--) begin
					if (held_stores[i].address == a) begin
						await_result(sbf_pkg::KIND_FORWARD, a, held_stores[i].value, 2'd0,
							1'b1);
						hit = 1'b1;
					end
				end
				if (!hit)
					await_result(sbf_pkg::KIND_READ_REQ, a, 64'd0, sz, 1'b1);
			end
			sbf_pkg::ACT_COMMIT: begin
				if (held_stores.size() == 0)
					await_result(sbf_pkg::KIND_POP_ERROR, 64'd0, 64'd0, 2'd0, 1'b1);
				else
					drain_oldest(1'b1);
			end
			default: begin
				while (held_stores.size() > 0)
					drain_oldest(held_stores.size() == 1);
			end
		endcase
	endfunction

	// Send one transaction, with an optional gap first, and predict it on acceptance
	task automatic send_op(sbf_pkg::action_t act, logic [63:0] a, logic [63:0] d,
			sbf_pkg::size_t sz);
		int gap;
		if (sender_jitter && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		address = a;
		store_data = d;
		size_code = sz;
		do @(posedge clk); while (!in_ready);
		predict_buffer(act, a, d, sz);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold until every expected result has arrived
	task automatic wait_for_drain();
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Stall the result side in random bursts
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				hold_left = $urandom_range(0, 4);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] got);
		if (exp !== got) begin
			$error("%s: expected %h, got %h", name, exp, got);
			failures++;
		end
	endfunction

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		result_t r;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: kind %0d address %h data %h", kind, mem_address,
					data_out);
				failures++;
			end else begin
				r = awaited_results.pop_front();
				check_field("kind", r.kind, kind);
				check_field("mem_address", r.mem_address, mem_address);
				check_field("data_out", r.data, data_out);
				check_field("width_out", r.width, width_out);
				check_field("last", r.last, last);
				kinds_seen[kind]++;
			end
		end
	end

	function automatic logic [63:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	// Pick an address: a held one with the given percent chance, else a neighbour or a fresh value
	function automatic logic [63:0] pick_address(int reuse_pct);
		int n;
		n = held_stores.size();
		if (n > 0 && $urandom_range(0, 99) < reuse_pct)
			return held_stores[$urandom_range(0, n - 1)].address;
		if (n > 0 && $urandom_range(0, 4) == 0)
			return held_stores[$urandom_range(0, n - 1)].address ^ (64'd1 << $urandom_range(0, 63));
		case ($urandom_range(0, 9))
			0:       return 64'd0;
			1:       return '1;
			default: return random_word();
		endcase
	endfunction

	// Operations on an empty buffer
	task automatic test_empty_buffer();
		send_op(sbf_pkg::ACT_COMMIT, random_word(), random_word(), sbf_pkg::SZ_64);
		send_op(sbf_pkg::ACT_FLUSH_ALL, random_word(), random_word(), sbf_pkg::SZ_8);
		send_op(sbf_pkg::ACT_LOAD, 64'h0000_0000_0000_0040, 64'd0, sbf_pkg::SZ_16);
	endtask

	// Fill past capacity with extreme fields and a shadowed address
	task automatic test_fill_and_overflow();
		send_op(sbf_pkg::ACT_STORE, '1, '1, sbf_pkg::SZ_8);
		send_op(sbf_pkg::ACT_STORE, 64'd0, '1, sbf_pkg::SZ_16);
		send_op(sbf_pkg::ACT_STORE, 64'h1000, 64'hDEAD_BEEF_CAFE_F00D, sbf_pkg::SZ_32);
		send_op(sbf_pkg::ACT_STORE, 64'h1000, 64'h0123_4567_89AB_CDEF, sbf_pkg::SZ_64);
		send_op(sbf_pkg::ACT_STORE, 64'h8000_0000_0000_0000, 64'd0, sbf_pkg::SZ_8);
		send_op(sbf_pkg::ACT_STORE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			sbf_pkg::SZ_16);
		send_op(sbf_pkg::ACT_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			sbf_pkg::SZ_32);
		send_op(sbf_pkg::ACT_STORE, 64'h1001, random_word(), sbf_pkg::SZ_64);
		send_op(sbf_pkg::ACT_STORE, 64'h2000, '1, sbf_pkg::SZ_64);
	endtask

	// Loads that hit the newest match, hit across widths, and miss
	task automatic test_forwarding();
		send_op(sbf_pkg::ACT_LOAD, 64'h1000, 64'd0, sbf_pkg::SZ_8);
		send_op(sbf_pkg::ACT_LOAD, 64'd0, 64'd0, sbf_pkg::SZ_64);
		send_op(sbf_pkg::ACT_LOAD, '1, 64'd0, sbf_pkg::SZ_32);
		send_op(sbf_pkg::ACT_LOAD, 64'h1002, '1, sbf_pkg::SZ_64);
	endtask

	// Commit one entry, then flush the rest
	task automatic test_commit_and_flush();
		send_op(sbf_pkg::ACT_COMMIT, 64'd0, 64'd0, sbf_pkg::SZ_8);
		send_op(sbf_pkg::ACT_FLUSH_ALL, '1, '1, sbf_pkg::SZ_64);
	endtask

	// Random traffic in chunks, each chunk with its own mix and, when asked, its own idling
	task automatic test_random_traffic(int n_items, bit vary_idle);
		int store_pct, load_pct, commit_pct, r;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				if ($urandom_range(0, 1)) begin
					store_pct = 65; load_pct = 95; commit_pct = 99;
				end else begin
					store_pct = 40; load_pct = 75; commit_pct = 90;
				end
				if (vary_idle) begin
					sender_jitter = $urandom_range(0, 3) != 0;
					receiver_stalls = $urandom_range(0, 3) != 0;
				end
			end
			r = $urandom_range(0, 99);
			if (r < store_pct)
				send_op(sbf_pkg::ACT_STORE, pick_address(30), random_word(),
					sbf_pkg::size_t'($urandom_range(0, 3)));
			else if (r < load_pct)
				send_op(sbf_pkg::ACT_LOAD, pick_address(60), random_word(),
					sbf_pkg::size_t'($urandom_range(0, 3)));
			else if (r < commit_pct)
				send_op(sbf_pkg::ACT_COMMIT, random_word(), random_word(),
					sbf_pkg::size_t'($urandom_range(0, 3)));
			else
				send_op(sbf_pkg::ACT_FLUSH_ALL, random_word(), random_word(),
					sbf_pkg::size_t'($urandom_range(0, 3)));
		end
	endtask

	// Pause the sender until the buffer's results have all come out
	task automatic test_pause_for_drain();
		send_op(sbf_pkg::ACT_STORE, random_word(), random_word(), sbf_pkg::SZ_32);
		send_op(sbf_pkg::ACT_FLUSH_ALL, 64'd0, 64'd0, sbf_pkg::SZ_8);
		wait_for_drain();
		@(negedge clk);
	endtask

	// Final stretch at full rate on both sides
	task automatic test_full_rate(int n_items);
		test_random_traffic(n_items, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = sbf_pkg::ACT_STORE;
		address = 64'd0;
		store_data = 64'd0;
		size_code = sbf_pkg::SZ_8;
		failures = 0;
		cycles = 0;
		items_sent = 0;
		sender_jitter = 1'b1;
		receiver_stalls = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_buffer();
		test_fill_and_overflow();
		test_forwarding();
		test_commit_and_flush();
		test_random_traffic(200, 1'b1);
		test_pause_for_drain();
		test_random_traffic(220, 1'b1);
		sender_jitter = 1'b0;
		receiver_stalls = 1'b0;
		test_full_rate(60);
		in_valid = 1'b0;

		// Wait for the last results, then let the block settle
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d expected results never arrived", awaited_results.size());
			failures++;
		end

		$display("Sent %0d transactions: stores, loads, commits and flushes with random idling.",
			items_sent);
		$display("Checked %0d commits, %0d forwards, %0d read requests, %0d empty-pop errors.",
			kinds_seen[sbf_pkg::KIND_COMMIT], kinds_seen[sbf_pkg::KIND_FORWARD],
			kinds_seen[sbf_pkg::KIND_READ_REQ], kinds_seen[sbf_pkg::KIND_POP_ERROR]);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
